// ----- sv/lfg_pkg.sv -----
`default_nettype none

package lfg_pkg;

  localparam int TABLE_LENGTH  = 607;
  localparam int RESEED_PERIOD = 10000000;
  localparam int ADDR_W        = $clog2(TABLE_LENGTH);
  localparam int COUNT_W       = $clog2(RESEED_PERIOD);
  localparam int WORD_W        = 31;
  localparam int SEED_W        = 32;
  localparam int MULT_W        = 14;
  localparam int PROD_W        = WORD_W + MULT_W;
  localparam int LCG_MULT      = 9069;
  localparam int START_FIRST   = 272;
  localparam int START_SECOND  = 606;
  localparam int LAG_GAP       = START_SECOND - START_FIRST;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [SEED_W-1:0]  seed_t;

  localparam word_t MODULUS  = '1;
  localparam addr_t LAST_ADDR = ADDR_W'(TABLE_LENGTH - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_FILL,
    ST_READ,
    ST_DRAW
  } state_t;

  // seed mod (2^31-1), then forced odd by subtracting one mod 2^31
  function automatic word_t prep_seed(seed_t s);
    logic [SEED_W-1:0] sum;
    word_t             r;
    sum = {1'b0, s[WORD_W-1:0]} + SEED_W'(s[SEED_W-1]);
    if (sum >= {1'b0, MODULUS}) begin
      sum = sum - {1'b0, MODULUS};
    end
    r = sum[WORD_W-1:0];
    if (!r[0]) begin
      r = r - word_t'(1);
    end
    return r;
  endfunction

  function automatic addr_t step_down(addr_t i);
    return (i == '0) ? LAST_ADDR : i - addr_t'(1);
  endfunction

endpackage

`default_nettype wire

// ----- sv/lagged_fibonacci_uniform_generator_unit.sv -----
// Subtractive lagged Fibonacci generator (lags 607/273, modulus 2^31-1) with its 607-word
// state in one two-read, one-write synchronous RAM. In a draw, the transaction is accepted
// and both lag words are read, then the difference is formed, written back and loaded into
// the result register (held there while result_stall is high). A seed transaction runs
// accept, seed reduction, a fill of all 607 words (one table word per cycle from the
// x*9069 mod 2^31 sequence), then a read and a draw. Every RESEED_PERIOD-th draw also
// refills the table from the drawn value within that transaction. After reset the table is
// cleared one word per cycle, so request_stall stays high until all 607 words are cleared.
// No new transaction is taken while one is in progress, but one is taken while a result
// still waits.
`default_nettype none

module lagged_fibonacci_uniform_generator_unit
  import lfg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              request_valid,
  output logic                   request_stall,
  input  wire logic              operation,
  input  wire logic [SEED_W-1:0] seed_value,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output logic [WORD_W-1:0]      value
);

  state_t state;
  state_t state_next;

  word_t  lag_mem [TABLE_LENGTH];
  word_t  rd_a;
  word_t  rd_b;

  addr_t  fill_addr;
  word_t  x;
  seed_t  seed_reg;
  addr_t  first_index;
  addr_t  second_index;
  count_t draw_count;
  logic   plain_draw;

  logic   mem_re;
  logic   mem_we;
  addr_t  mem_waddr;
  word_t  mem_wdata;
  logic   load_result;
  logic   draw_commit;
  logic   out_free;
  logic   last_addr;
  logic   request_take;

  logic [PROD_W-1:0]  prod;
  word_t              x_mult;
  logic [WORD_W:0]    diff_wide;
  word_t              k;
  logic [COUNT_W:0]   count_inc;
  logic               reseed_hit;

  assign prod      = {{MULT_W{1'b0}}, x} * PROD_W'(LCG_MULT);
  assign x_mult    = prod[WORD_W-1:0];
  assign last_addr = (fill_addr == LAST_ADDR);
  assign out_free  = !result_valid || !result_stall;

  always_comb begin
    if (rd_a >= rd_b) begin
      diff_wide = {1'b0, rd_a} - {1'b0, rd_b};
    end else begin
      diff_wide = {1'b0, rd_a} + {1'b0, MODULUS} - {1'b0, rd_b};
    end
  end
  assign k = diff_wide[WORD_W-1:0];

  assign count_inc  = {1'b0, draw_count} + (COUNT_W+1)'(1);
  assign reseed_hit = (count_inc >= (COUNT_W+1)'(RESEED_PERIOD));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (last_addr) state_next = ST_IDLE;
      ST_IDLE: begin
        if (request_valid) state_next = operation ? ST_PREP : ST_DRAW;
      end
      ST_PREP:  state_next = ST_FILL;
      ST_FILL:  if (last_addr) state_next = ST_READ;
      ST_READ:  state_next = ST_DRAW;
      ST_DRAW: begin
        if (plain_draw) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          state_next = reseed_hit ? ST_PREP : ST_IDLE;
        end
      end
      default:  state_next = ST_CLEAR;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    request_stall = (state != ST_IDLE);
    request_take  = (state == ST_IDLE) && request_valid;
    mem_re        = (request_take && !operation) || (state == ST_READ);
    draw_commit   = (state == ST_DRAW) && (plain_draw || out_free);
    load_result   = (state == ST_DRAW) && !plain_draw && out_free;
    mem_we        = 1'b0;
    mem_waddr     = fill_addr;
    mem_wdata     = '0;
    unique case (state)
      ST_CLEAR: mem_we = 1'b1;
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = x_mult;
      end
      ST_DRAW: begin
        // a reseeding draw does not write back; the refill overwrites the table
        mem_we    = draw_commit && (plain_draw || !reseed_hit);
        mem_waddr = second_index;
        mem_wdata = k;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lag_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_a <= lag_mem[first_index];
      rd_b <= lag_mem[second_index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_addr <= '0;
    end else if (state == ST_CLEAR || state == ST_FILL) begin
      fill_addr <= last_addr ? '0 : fill_addr + addr_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_PREP) begin
      x <= prep_seed(seed_reg);
    end else if (state == ST_FILL) begin
      x <= x_mult;
    end
  end

  always_ff @(posedge clk) begin
    if (request_take && operation) begin
      seed_reg <= seed_value;
    end else if (load_result && reseed_hit) begin
      seed_reg <= {1'b0, k};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_index  <= addr_t'(START_FIRST);
      second_index <= addr_t'(START_SECOND);
    end else if (state == ST_FILL && last_addr) begin
      first_index  <= addr_t'(START_FIRST);
      second_index <= addr_t'(START_SECOND);
    end else if (state == ST_DRAW && mem_we) begin
      first_index  <= step_down(first_index);
      second_index <= step_down(second_index);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draw_count <= '0;
      plain_draw <= 1'b0;
    end else if (draw_commit) begin
      if (plain_draw) begin
        draw_count <= count_inc[COUNT_W-1:0];
        plain_draw <= 1'b0;
      end else if (reseed_hit) begin
        draw_count <= '0;
        plain_draw <= 1'b1;
      end else begin
        draw_count <= count_inc[COUNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      value <= k;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_lag_gap: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, first_index} + (ADDR_W+1)'(LAG_GAP) == {1'b0, second_index}) ||
    ({1'b0, second_index} + (ADDR_W+1)'(TABLE_LENGTH - LAG_GAP) == {1'b0, first_index}))
    else $error("lag indices lost their fixed distance");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("table read and write in the same cycle");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, draw_count} < (COUNT_W+1)'(RESEED_PERIOD))
    else $error("draw count reached reseed period");

  a_plain_after_fill: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAW && plain_draw) |-> $past(state) == ST_READ)
    else $error("post-reseed draw without a preceding refill");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (load_result && result_valid) |-> !result_stall)
    else $error("result register overwritten while held");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/lagged_fibonacci_uniform_generator_unit_tb.sv -----
`timescale 1ns / 100ps

module lagged_fibonacci_uniform_generator_unit_tb;
  import lfg_pkg::*;

  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_SEED = 1'b1;
  localparam int RANDOM_ITEMS = 2000;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_AT_RESULT = 400;
  localparam int HOLD_CYCLES = 800;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic  op;
    seed_t seed;
    logic  drain;  // wait for every outstanding result before offering
  } lfg_request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic request_valid = 1'b0;
  logic request_stall;
  logic operation = OP_DRAW;
  seed_t seed_value = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  word_t value;

  lagged_fibonacci_uniform_generator_unit DUT (
    .clk(clk),
    .rst(rst),
    .request_valid(request_valid),
    .request_stall(request_stall),
    .operation(operation),
    .seed_value(seed_value),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .value(value)
  );

  always #6 clk = ~clk;

  // generator state as predicted
  word_t lag_words [TABLE_LENGTH];
  int lag_first;
  int lag_second;
  int draws_since_reseed;

  lfg_request_t pending_requests[$];
  word_t expected_values[$];
  int requests_taken = 0;
  int results_seen = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic fill_lag_table(input seed_t seed);
    logic [63:0] x;
    x = {32'b0, seed} % 64'h7FFF_FFFF;
    // even reduced values drop by one mod 2^31, so zero lands on 2^31-1
    if (!x[0]) x = (x + 64'h7FFF_FFFF) & 64'h7FFF_FFFF;
    for (int i = 0; i < TABLE_LENGTH; i++) begin
      x = (x * LCG_MULT) & 64'h7FFF_FFFF;
      lag_words[i] = x[WORD_W-1:0];
    end
    lag_first = START_FIRST;
    lag_second = START_SECOND;
  endtask

  function automatic word_t lag_difference();
    word_t a;
    word_t b;
    a = lag_words[lag_first];
    b = lag_words[lag_second];
    if (a >= b) return a - b;
    return word_t'({1'b0, a} + 32'h7FFF_FFFF - {1'b0, b});
  endfunction

  task automatic write_back_and_step(input word_t k);
    lag_words[lag_second] = k;
    lag_first = (lag_first == 0) ? TABLE_LENGTH - 1 : lag_first - 1;
    lag_second = (lag_second == 0) ? TABLE_LENGTH - 1 : lag_second - 1;
  endtask

  task automatic draw_lag_value(output word_t k);
    word_t refill_draw;
    k = lag_difference();
    draws_since_reseed = draws_since_reseed + 1;
    if (draws_since_reseed >= RESEED_PERIOD) begin
      // automatic reseed: table refilled from k, its own draw is discarded
      draws_since_reseed = 0;
      fill_lag_table(seed_t'(k));
      refill_draw = lag_difference();
      draws_since_reseed = (draws_since_reseed + 1) & 24'hFF_FFFF;
      write_back_and_step(refill_draw);
    end else begin
      draws_since_reseed = draws_since_reseed & 24'hFF_FFFF;
      write_back_and_step(k);
    end
  endtask

  task automatic queue_request(input logic op, input seed_t seed, input logic drain);
    lfg_request_t r;
    r.op = op;
    r.seed = seed;
    r.drain = drain;
    pending_requests.push_back(r);
  endtask

  // sender: bursts of transactions separated by random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    lfg_request_t head;
    word_t predicted;
    logic offer;
    logic took;
    if (rst) begin
      request_valid <= 1'b0;
    end else begin
      offer = request_valid;
      took = 1'b0;
      if (request_valid && !request_stall) begin
        if (operation == OP_SEED) fill_lag_table(seed_value);
        draw_lag_value(predicted);
        expected_values.push_back(predicted);
        requests_taken <= requests_taken + 1;
        offer = 1'b0;
        took = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_requests.size() > 0) begin
          head = pending_requests[0];
          // the count taken at this edge is not visible yet, so a drain waits while took is set
          if (!head.drain || (!took && requests_taken == results_seen)) begin
            void'(pending_requests.pop_front());
            operation <= head.op;
            seed_value <= head.seed;
            offer = 1'b1;
          end
        end
      end
      request_valid <= offer;
    end
  end

  // receiver: stall density changes in phases, plus one long hold-off
  int stall_mode = 0;
  int mode_left = 50;
  int hold_left = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin
    logic stall_next;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (!hold_done && results_seen == HOLD_AT_RESULT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(32, 256);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: stall_next = 1'b0;
        1: stall_next = ($urandom_range(0, 3) == 0);
        2: stall_next = ($urandom_range(0, 3) != 0);
        default: stall_next = ~result_stall;
      endcase
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end
      result_stall <= stall_next;
    end
  end

  // result monitor
  always @(posedge clk) begin
    word_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_values.size() == 0) begin
        report_mismatch($sformatf("result %h with no transaction outstanding", value));
      end else begin
        want = expected_values.pop_front();
        if (value !== want)
          report_mismatch($sformatf("result %0d: value %h, expected %h",
                                    results_seen, value, want));
      end
      results_seen <= results_seen + 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("lagged_fibonacci_uniform_generator_unit_tb NOT OK");
      $finish;
    end
  end

  initial begin
    int queued;
    int run_len;
    seed_t s;
    seed_t special_seeds [9];

    special_seeds = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h7FFF_FFFE,
                      32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFE,
                      32'hFFFF_FFFF};

    foreach (lag_words[i]) lag_words[i] = '0;
    lag_first = START_FIRST;
    lag_second = START_SECOND;
    draws_since_reseed = 0;

    // draws from the cleared table return zero
    queue_request(OP_DRAW, 32'h0, 1'b0);
    queue_request(OP_DRAW, 32'hFFFF_FFFF, 1'b0);
    queue_request(OP_DRAW, 32'h0, 1'b0);
    // zero seed and seeds that reduce to zero, one, or an even value
    queue_request(OP_SEED, 32'h0000_0000, 1'b0);
    queue_request(OP_DRAW, 32'h0, 1'b0);
    queue_request(OP_SEED, 32'h7FFF_FFFF, 1'b0);
    queue_request(OP_DRAW, 32'h0, 1'b0);
    queue_request(OP_SEED, 32'h8000_0000, 1'b0);
    queue_request(OP_SEED, 32'hFFFF_FFFF, 1'b0);
    queue_request(OP_SEED, 32'hFFFF_FFFE, 1'b0);
    queue_request(OP_SEED, 32'h7FFF_FFFE, 1'b0);
    queue_request(OP_SEED, 32'h0000_0001, 1'b0);
    queue_request(OP_DRAW, 32'h0, 1'b0);
    queue_request(OP_DRAW, 32'h0, 1'b0);
    queue_request(OP_SEED, 32'h0000_0002, 1'b0);
    queue_request(OP_SEED, 32'h8000_0001, 1'b0);
    queue_request(OP_SEED, 32'hAAAA_AAAA, 1'b0);
    queue_request(OP_SEED, 32'h5555_5555, 1'b0);
    queue_request(OP_DRAW, 32'h0, 1'b0);
    queue_request(OP_DRAW, 32'h0, 1'b0);

    // seeded runs of draws with random lengths; a few wait for a full drain
    queued = 0;
    while (queued < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) s = special_seeds[$urandom_range(0, 8)];
      else s = $urandom;
      queue_request(OP_SEED, s, (queued == 0) || ($urandom_range(0, 19) == 0));
      queued++;
      // occasionally one long run that wraps the first table position and can wrap the second
      run_len = ($urandom_range(0, 24) == 0) ? $urandom_range(300, 700)
                                             : $urandom_range(0, 40);
      for (int i = 0; i < run_len && queued < RANDOM_ITEMS; i++) begin
        queue_request(OP_DRAW, $urandom, 1'b0);
        queued++;
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() > 0 || request_valid) @(posedge clk);
    while (requests_taken != results_seen) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_values.size() == 0) begin
      $display("lagged_fibonacci_uniform_generator_unit_tb OK");
    end else begin
      $display("lagged_fibonacci_uniform_generator_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
